// ===== hw/rtl/circle_tangent_waypoint_unit_macros.svh =====
// Assertion macros shared by the tangent waypoint RTL.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef CIRCLE_TANGENT_WAYPOINT_UNIT_MACROS_SVH
`define CIRCLE_TANGENT_WAYPOINT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ctw_pkg.sv =====
// Shared widths, register codes and types of the tangent waypoint unit.
// No dependencies.
`timescale 1ns / 1ps

package ctw_pkg;

  localparam int CW   = 16;
  localparam int DW   = CW + 1;
  localparam int RW   = CW - 1;
  localparam int D2W  = 2 * DW;
  localparam int R2W  = 2 * RW;
  localparam int RADW = D2W + 8;
  localparam int SW   = RADW / 2;
  localparam int RSW  = RW + SW;
  localparam int AXW  = R2W + 1 + DW;
  localparam int BXW  = RSW + 1 + DW;
  localparam int NW   = BXW + 1;
  localparam int DENW = D2W + 4;
  localparam int QW   = CW;
  localparam int TW   = CW + 2;
  localparam int EW   = TW + 1;
  localparam int ESQW = 2 * EW;
  localparam int NL   = 4;
  localparam int AW   = 4;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  typedef struct packed {
    logic                   in_circle;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic [D2W-1:0]         d2;
    logic [R2W-1:0]         r2;
    logic signed [CW-1:0]   rx;
    logic signed [CW-1:0]   ry;
    logic signed [CW-1:0]   gx;
    logic signed [CW-1:0]   gy;
  } geo_t;

  typedef struct packed {
    logic                   in_circle;
    logic [NL-1:0]          neg;
    logic signed [CW-1:0]   rx;
    logic signed [CW-1:0]   ry;
    logic signed [CW-1:0]   gx;
    logic signed [CW-1:0]   gy;
  } sel_t;

  typedef struct packed {
    logic [CW-1:0] tangent_x;
    logic [CW-1:0] tangent_y;
    logic          chosen_side;
    logic          inside_flag;
  } res_t;

  function automatic logic [CW-1:0] sat_coord(input logic signed [TW-1:0] v);
    logic [CW-1:0] r;
    if ((&v[TW-1:CW-1]) || !(|v[TW-1:CW-1])) begin
      r = v[CW-1:0];
    end else if (v[TW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/circle_tangent_waypoint_unit.sv =====
// Top level of the tangent waypoint unit: registers, pipeline and output skid.
// Depends on ctw_pkg, ctw_sqrt, ctw_div and the assertion macro header.
//
//   channel   direction   handshake              payload
//   in        request in  in_valid / in_stall    robot_x, robot_y, goal_x, goal_y
//   out       result out  out_valid / out_stall  tangent_x, tangent_y, side, inside
//   cfg       APB write   psel/penable/pwrite    center_x, center_y, radius
//
// One request enters per cycle unless in_stall is high.
// The pipeline contains the 21-stage square root and the 16-stage dividers.
// Reset is synchronous and clears the valid bits and the circle registers.
// While a second result waits in the skid stage the whole pipeline holds.
`timescale 1ns / 1ps
`include "circle_tangent_waypoint_unit_macros.svh"

module circle_tangent_waypoint_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ctw_pkg::CW-1:0] in_robot_x,
  input  logic signed [ctw_pkg::CW-1:0] in_robot_y,
  input  logic signed [ctw_pkg::CW-1:0] in_goal_x,
  input  logic signed [ctw_pkg::CW-1:0] in_goal_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ctw_pkg::CW-1:0] out_tangent_x,
  output logic signed [ctw_pkg::CW-1:0] out_tangent_y,
  output logic                        out_chosen_side,
  output logic                        out_inside_flag,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctw_pkg::AW-1:0]      paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ctw_pkg::*;

  logic signed [CW-1:0] cx_r, cy_r;
  logic [RW-1:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CENTER_X: cx_r  <= pwdata[CW-1:0];
        REG_CENTER_Y: cy_r  <= pwdata[CW-1:0];
        REG_RADIUS:   rad_r <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CENTER_X: prdata = 32'(cx_r);
      REG_CENTER_Y: prdata = 32'(cy_r);
      REG_RADIUS:   prdata = 32'(rad_r);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  logic adv;
  logic skid_v_r;
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // Stage 1: offsets from the centre.
  logic                 s1_v_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r;
  logic signed [CW-1:0] s1_rx_r, s1_ry_r, s1_gx_r, s1_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= DW'(in_robot_x) - DW'(cx_r);
      s1_dy_r <= DW'(in_robot_y) - DW'(cy_r);
      s1_rx_r <= in_robot_x;
      s1_ry_r <= in_robot_y;
      s1_gx_r <= in_goal_x;
      s1_gy_r <= in_goal_y;
    end
  end

  // Stage 2: squares.
  logic                 s2_v_r;
  logic [D2W-1:0]       s2_dx2_r, s2_dy2_r;
  logic [R2W-1:0]       s2_r2_r;
  logic signed [DW-1:0] s2_dx_r, s2_dy_r;
  logic signed [CW-1:0] s2_rx_r, s2_ry_r, s2_gx_r, s2_gy_r;
  logic signed [D2W-1:0] dx2_w, dy2_w;

  assign dx2_w = D2W'(s1_dx_r) * D2W'(s1_dx_r);
  assign dy2_w = D2W'(s1_dy_r) * D2W'(s1_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dx2_r <= dx2_w;
      s2_dy2_r <= dy2_w;
      s2_r2_r  <= R2W'(rad_r) * R2W'(rad_r);
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_rx_r  <= s1_rx_r;
      s2_ry_r  <= s1_ry_r;
      s2_gx_r  <= s1_gx_r;
      s2_gy_r  <= s1_gy_r;
    end
  end

  // Stage 3: distance, inside test and root operand.
  logic            s3_v_r;
  geo_t            s3_g_r;
  logic [RADW-1:0] s3_rad_r;
  logic [D2W-1:0]  d2_w;
  logic            inside_w;

  assign d2_w     = s2_dx2_r + s2_dy2_r;
  assign inside_w = d2_w <= D2W'(s2_r2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_g_r.in_circle <= inside_w;
      s3_g_r.dx        <= s2_dx_r;
      s3_g_r.dy        <= s2_dy_r;
      s3_g_r.d2        <= d2_w;
      s3_g_r.r2        <= s2_r2_r;
      s3_g_r.rx        <= s2_rx_r;
      s3_g_r.ry        <= s2_ry_r;
      s3_g_r.gx        <= s2_gx_r;
      s3_g_r.gy        <= s2_gy_r;
      s3_rad_r         <= inside_w ? '0 : {d2_w - D2W'(s2_r2_r), 8'd0};
    end
  end

  // Square root with its matching side band.
  logic [SW-1:0] root_w;
  logic          sq_v_r [SW];
  geo_t          sq_g_r [SW];

  ctw_sqrt u_sqrt (
    .clk      (clk),
    .adv      (adv),
    .radicand (s3_rad_r),
    .root     (root_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SW; i++) sq_v_r[i] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= s3_v_r;
      for (int i = 1; i < SW; i++) sq_v_r[i] <= sq_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_g_r[0] <= s3_g_r;
      for (int i = 1; i < SW; i++) sq_g_r[i] <= sq_g_r[i-1];
    end
  end

  // M1: radius times root.
  logic           m1_v_r;
  geo_t           m1_g_r;
  logic [RSW-1:0] m1_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= sq_v_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_g_r  <= sq_g_r[SW-1];
      m1_rs_r <= RSW'(rad_r) * RSW'(root_w);
    end
  end

  // M2: the four products.
  logic                  m2_v_r;
  geo_t                  m2_g_r;
  logic signed [AXW-1:0] m2_ax_r, m2_ay_r;
  logic signed [BXW-1:0] m2_bx_r, m2_by_r;
  logic [DENW-1:0]       m2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_g_r   <= m1_g_r;
      m2_ax_r  <= $signed(AXW'({1'b0, m1_g_r.r2})) * AXW'(m1_g_r.dx);
      m2_ay_r  <= $signed(AXW'({1'b0, m1_g_r.r2})) * AXW'(m1_g_r.dy);
      m2_bx_r  <= $signed(BXW'({1'b0, m1_rs_r})) * BXW'(m1_g_r.dy);
      m2_by_r  <= $signed(BXW'({1'b0, m1_rs_r})) * BXW'(m1_g_r.dx);
      m2_den_r <= {m1_g_r.d2, 4'd0};
    end
  end

  // M3: numerators of both tangents.
  logic                 m3_v_r;
  logic signed [NW-1:0] m3_n_r [NL];
  logic [DENW-1:0]      m3_den_r;
  sel_t                 m3_s_r;
  logic signed [NW-1:0] ax16_w, ay16_w, bx_w, by_w;

  assign ax16_w = NW'(m2_ax_r) <<< 4;
  assign ay16_w = NW'(m2_ay_r) <<< 4;
  assign bx_w   = NW'(m2_bx_r);
  assign by_w   = NW'(m2_by_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (adv) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_n_r[0]        <= ax16_w - bx_w;
      m3_n_r[1]        <= ay16_w + by_w;
      m3_n_r[2]        <= ax16_w + bx_w;
      m3_n_r[3]        <= ay16_w - by_w;
      m3_den_r         <= m2_den_r;
      m3_s_r.in_circle <= m2_g_r.in_circle;
      m3_s_r.neg       <= '0;
      m3_s_r.rx        <= m2_g_r.rx;
      m3_s_r.ry        <= m2_g_r.ry;
      m3_s_r.gx        <= m2_g_r.gx;
      m3_s_r.gy        <= m2_g_r.gy;
    end
  end

  // M4: magnitudes with the rounding offset.
  logic            m4_v_r;
  logic [NW-1:0]   m4_mag_r [NL];
  logic [DENW-1:0] m4_den_r;
  sel_t            m4_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_v_r <= 1'b0;
    end else if (adv) begin
      m4_v_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        m4_mag_r[j] <= (m3_n_r[j][NW-1] ? NW'(-m3_n_r[j]) : NW'(m3_n_r[j]))
                       + NW'(m3_den_r >> 1);
      end
      m4_den_r         <= m3_den_r;
      m4_s_r.in_circle <= m3_s_r.in_circle;
      m4_s_r.rx        <= m3_s_r.rx;
      m4_s_r.ry        <= m3_s_r.ry;
      m4_s_r.gx        <= m3_s_r.gx;
      m4_s_r.gy        <= m3_s_r.gy;
      for (int j = 0; j < NL; j++) m4_s_r.neg[j] <= m3_n_r[j][NW-1];
    end
  end

  // Dividers with their matching side band.
  logic [QW-1:0] q_w [NL];
  logic          dv_v_r [QW];
  sel_t          dv_s_r [QW];

  for (genvar j = 0; j < NL; j++) begin : g_lane
    ctw_div u_div (
      .clk (clk),
      .adv (adv),
      .num (m4_mag_r[j]),
      .den (m4_den_r),
      .quo (q_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) dv_v_r[i] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= m4_v_r;
      for (int i = 1; i < QW; i++) dv_v_r[i] <= dv_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_s_r[0] <= m4_s_r;
      for (int i = 1; i < QW; i++) dv_s_r[i] <= dv_s_r[i-1];
    end
  end

  // P1: candidate points.
  logic                 p1_v_r;
  logic signed [TW-1:0] p1_t_r [NL];
  sel_t                 p1_s_r;
  logic signed [TW-1:0] qs_w [NL];

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      qs_w[j] = dv_s_r[QW-1].neg[j] ? -$signed(TW'(q_w[j])) : $signed(TW'(q_w[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= dv_v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_t_r[0] <= TW'(cx_r) + qs_w[0];
      p1_t_r[1] <= TW'(cy_r) + qs_w[1];
      p1_t_r[2] <= TW'(cx_r) + qs_w[2];
      p1_t_r[3] <= TW'(cy_r) + qs_w[3];
      p1_s_r    <= dv_s_r[QW-1];
    end
  end

  // P2: squared distances to the goal, per axis.
  logic                 p2_v_r;
  logic [ESQW-1:0]      p2_sq_r [NL];
  logic signed [TW-1:0] p2_t_r  [NL];
  sel_t                 p2_s_r;
  logic signed [EW-1:0] e_w [NL];

  assign e_w[0] = EW'(p1_s_r.gx) - EW'(p1_t_r[0]);
  assign e_w[1] = EW'(p1_s_r.gy) - EW'(p1_t_r[1]);
  assign e_w[2] = EW'(p1_s_r.gx) - EW'(p1_t_r[2]);
  assign e_w[3] = EW'(p1_s_r.gy) - EW'(p1_t_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        p2_sq_r[j] <= ESQW'(e_w[j]) * ESQW'(e_w[j]);
        p2_t_r[j]  <= p1_t_r[j];
      end
      p2_s_r <= p1_s_r;
    end
  end

  // Choice, saturation and output stage with skid.
  logic [ESQW:0] e1_w, e2_w;
  logic          side_w;
  res_t          res_w;
  res_t          out_r, skid_r;
  logic          out_valid_r;
  logic          push, pop;

  assign e1_w   = (ESQW+1)'(p2_sq_r[0]) + (ESQW+1)'(p2_sq_r[1]);
  assign e2_w   = (ESQW+1)'(p2_sq_r[2]) + (ESQW+1)'(p2_sq_r[3]);
  assign side_w = e1_w > e2_w;

  always_comb begin
    if (p2_s_r.in_circle) begin
      res_w.tangent_x   = p2_s_r.rx;
      res_w.tangent_y   = p2_s_r.ry;
      res_w.chosen_side = 1'b0;
      res_w.inside_flag = 1'b1;
    end else begin
      res_w.tangent_x   = sat_coord(side_w ? p2_t_r[2] : p2_t_r[0]);
      res_w.tangent_y   = sat_coord(side_w ? p2_t_r[3] : p2_t_r[1]);
      res_w.chosen_side = side_w;
      res_w.inside_flag = 1'b0;
    end
  end

  assign push = p2_v_r && adv;
  assign pop  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= res_w;
      end else begin
        out_r <= res_w;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_r.tangent_x;
  assign out_tangent_y   = out_r.tangent_y;
  assign out_chosen_side = out_r.chosen_side;
  assign out_inside_flag = out_r.inside_flag;

  `CTW_ASSERT_SAME(a_skid_needs_out, skid_v_r, out_valid_r, "skid holds a result without output")
  `CTW_ASSERT_SAME(a_inside_side, out_valid_r && out_r.inside_flag, !out_r.chosen_side, "inside result with second side")
  `CTW_ASSERT_NEXT(a_skid_holds, skid_v_r && out_stall, skid_v_r, "skid result dropped under stall")
  `CTW_ASSERT_NEXT(a_skid_drain, skid_v_r && !out_stall, out_valid_r && !skid_v_r, "skid drain lost a result")

endmodule

// ===== hw/rtl/ctw_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on ctw_pkg.
`timescale 1ns / 1ps

module ctw_sqrt (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [ctw_pkg::RADW-1:0]  radicand,
  output logic [ctw_pkg::SW-1:0]    root
);
  import ctw_pkg::*;

  logic [RADW-1:0] rem_r  [SW];
  logic [SW-1:0]   root_r [SW];

  for (genvar g = 0; g < SW; g++) begin : g_stage
    localparam int B = SW - 1 - g;
    logic [RADW-1:0] rem_in;
    logic [SW-1:0]   root_in;
    logic [RADW:0]   trial;
    logic [RADW:0]   diff;

    if (g == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    assign trial = ((RADW+1)'(root_in) << (B + 1)) | ((RADW+1)'(1) << (2 * B));
    assign diff  = {1'b0, rem_in} - trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[RADW]) begin
          rem_r[g]  <= diff[RADW-1:0];
          root_r[g] <= root_in | (SW'(1) << B);
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in;
        end
      end
    end
  end

  assign root = root_r[SW-1];

endmodule

// ===== hw/rtl/ctw_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ctw_pkg.
`timescale 1ns / 1ps

module ctw_div (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [ctw_pkg::NW-1:0]    num,
  input  logic [ctw_pkg::DENW-1:0]  den,
  output logic [ctw_pkg::QW-1:0]    quo
);
  import ctw_pkg::*;

  logic [NW-1:0]   rem_r [QW];
  logic [DENW-1:0] den_r [QW];
  logic [QW-1:0]   q_r   [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int K = QW - 1 - g;
    logic [NW-1:0]   rem_in;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   q_in;
    logic [NW:0]     sub;

    if (g == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign q_in   = q_r[g-1];
    end

    assign sub = {1'b0, rem_in} - ((NW+1)'(den_in) << K);

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[g] <= den_in;
        if (!sub[NW]) begin
          rem_r[g] <= sub[NW-1:0];
          q_r[g]   <= q_in | (QW'(1) << K);
        end else begin
          rem_r[g] <= rem_in;
          q_r[g]   <= q_in;
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule
